@@ sv/mbs_pkg.sv @@
// ---------------------------------------------------------------------------
// Markup blanking scanner package
// Shared constants, types and character helpers for the scanner block.
// ---------------------------------------------------------------------------
package mbs_pkg;

	// Default limits of the design.
	localparam int MAX_NAME_CHARS_DEF = 8;
	localparam int CHECK_NAMES_DEF    = 4;

	// Configuration port geometry.
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int USED_W     = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_NAME_0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECK_NAMES_USED = 3'd4;

	// Reset values of the configuration registers ("alt" in the low bytes).
	localparam logic [CFG_DATA_W-1:0] CHECK_NAME_0_RST = 64'd7629921;
	localparam logic [USED_W-1:0]     CHECK_NAMES_USED_RST = 3'd1;

	// Characters the scanner reacts to.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Region of the tag the scanner is in.
	typedef enum logic [1:0] {
		RG_KEY     = 2'd0,
		RG_VALUE   = 2'd1,
		RG_CHECKED = 2'd2,
		RG_OTHER   = 2'd3
	} region_t;

	// Whitespace is space, tab, LF, VT, FF and CR.
	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
	endfunction

	// Lowercase ASCII A-Z only.
	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c inside {[8'd65:8'd90]}) ? (c + 8'd32) : c;
	endfunction

endpackage

@@ sv/markup_blanking_scanner_unit.sv @@
// ---------------------------------------------------------------------------
// Markup blanking scanner unit
// Marks text bytes that belong to SGML/HTML markup and replaces them with
// spaces, leaving values of configured attributes visible.
// ---------------------------------------------------------------------------
// The unit takes one byte per clock cycle while the output side is not
// stalled, and returns one result beat per byte, in order. Each byte
// passes through the input register and then the result register, whose
// beat drives the outputs. The scan step and the attribute name compare
// run combinationally between the input register and the result register,
// so the scan step sets the rate. in_ready follows out_ready
// combinationally when both registers are full.
// Configuration writes must only happen while no byte is in flight.
module markup_blanking_scanner_unit
	import mbs_pkg::*;
#(
	parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF,
	parameter int CHECK_NAMES    = CHECK_NAMES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_char,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  blank,
	output logic [7:0]            out_char
);

	localparam int NAME_W = 8 * MAX_NAME_CHARS;

	logic [CFG_DATA_W-1:0] check_name_q [CHECK_NAMES];
	logic [USED_W-1:0]     check_names_used_q;
	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  out_valid_q;
	logic                  blank_q;
	logic [7:0]            out_char_q;
	logic                  advance;
	logic                  step;
	logic                  match;
	logic                  blank_c;
	logic [NAME_W-1:0]     attr_name;
	logic                  attr_name_overflow;

	// The result register frees when empty or taken; the input register
	// moves on whenever the result register can take its beat.
	assign advance   = !out_valid_q || out_ready;
	assign step      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign blank     = blank_q;
	assign out_char  = out_char_q;

	// Configuration registers; writes to absent registers are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHECK_NAMES; i++) begin
				check_name_q[i] <= (i == 0) ? CHECK_NAME_0_RST : '0;
			end
			check_names_used_q <= CHECK_NAMES_USED_RST;
		end else if (wr_en) begin
			for (int i = 0; i < CHECK_NAMES; i++) begin
				if (wr_index == (CFG_CHECK_NAME_0 + CFG_IDX_W'(i))) begin
					check_name_q[i] <= wr_data;
				end
			end
			if (wr_index == CFG_CHECK_NAMES_USED) begin
				check_names_used_q <= wr_data[USED_W-1:0];
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
		end
	end

	// Attribute name compare.
	mbs_match #(
		.MAX_NAME_CHARS(MAX_NAME_CHARS),
		.CHECK_NAMES(CHECK_NAMES)
	) u_match (
		.check_name(check_name_q),
		.check_names_used(check_names_used_q),
		.attr_name(attr_name),
		.attr_name_overflow(attr_name_overflow),
		.match(match)
	);

	// Scan state and blank decision.
	mbs_scan #(
		.MAX_NAME_CHARS(MAX_NAME_CHARS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.c(char_s1),
		.match(match),
		.attr_name(attr_name),
		.attr_name_overflow(attr_name_overflow),
		.blank(blank_c)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			blank_q    <= blank_c;
			out_char_q <= blank_c ? CH_SPACE : char_s1;
		end
	end

endmodule

@@ sv/mbs_match.sv @@
// ---------------------------------------------------------------------------
// Markup blanking scanner: attribute name compare
// Compares the collected attribute name with the configured checked names.
// ---------------------------------------------------------------------------
module mbs_match
	import mbs_pkg::*;
#(
	parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF,
	parameter int CHECK_NAMES    = CHECK_NAMES_DEF,
	localparam int NAME_W        = 8 * MAX_NAME_CHARS
) (
	input  logic [CFG_DATA_W-1:0] check_name [CHECK_NAMES],
	input  logic [USED_W-1:0]     check_names_used,
	input  logic [NAME_W-1:0]     attr_name,
	input  logic                  attr_name_overflow,
	output logic                  match
);

	logic [CFG_DATA_W-1:0] name_ext;

	assign name_ext = CFG_DATA_W'(attr_name);

	// A register takes part only when its place is below the used count;
	// a used count above the register count leaves all of them in.
	always_comb begin
		match = 1'b0;
		for (int i = 0; i < CHECK_NAMES; i++) begin
			if ((check_names_used > USED_W'(i)) && (check_name[i] == name_ext)) begin
				match = 1'b1;
			end
		end
		if (attr_name_overflow) begin
			match = 1'b0;
		end
	end

endmodule

@@ sv/mbs_scan.sv @@
// ---------------------------------------------------------------------------
// Markup blanking scanner: scan state and step logic
// Holds the tag, quote, region and name state and decides for each byte
// whether it is markup.
// ---------------------------------------------------------------------------
module mbs_scan
	import mbs_pkg::*;
#(
	parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF,
	localparam int NAME_W        = 8 * MAX_NAME_CHARS,
	localparam int LEN_W         = $clog2(MAX_NAME_CHARS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        c,
	input  logic              match,
	output logic [NAME_W-1:0] attr_name,
	output logic              attr_name_overflow,
	output logic              blank
);

	logic              inside_tag_q, inside_tag_n;
	logic [7:0]        open_quote_q, open_quote_n;
	logic              token_starting_q, token_starting_n;
	region_t           region_q, region_n;
	logic [NAME_W-1:0] attr_name_q, attr_name_n;
	logic [LEN_W-1:0]  attr_len_q, attr_len_n;
	logic              overflow_q, overflow_n;
	logic              closed_q, closed_n;
	logic [7:0]        c_low;
	logic              no_quote;
	logic              eq_hit;

	assign c_low              = to_lower(c);
	assign no_quote           = (open_quote_q == CH_NUL);
	assign attr_name          = attr_name_q;
	assign attr_name_overflow = overflow_q;

	// Next state and the blank decision for the byte in hand.
	always_comb begin
		inside_tag_n     = inside_tag_q;
		open_quote_n     = open_quote_q;
		token_starting_n = token_starting_q;
		region_n         = region_q;
		attr_name_n      = attr_name_q;
		attr_len_n       = attr_len_q;
		overflow_n       = overflow_q;
		closed_n         = closed_q;
		eq_hit           = 1'b0;
		blank            = 1'b0;

		if (no_quote && (c == CH_LT)) begin
			inside_tag_n     = 1'b1;
			region_n         = RG_KEY;
			token_starting_n = 1'b1;
			blank            = 1'b1;
		end else if (no_quote && (c == CH_GT)) begin
			inside_tag_n = 1'b0;
			blank        = 1'b1;
		end else if (inside_tag_q) begin
			if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
				if (no_quote) begin
					open_quote_n = c;
				end else if (open_quote_q == c) begin
					open_quote_n = CH_NUL;
				end
			end else if (no_quote && is_space(c)) begin
				if (!token_starting_q) begin
					region_n         = RG_KEY;
					token_starting_n = 1'b1;
				end
			end else if (no_quote && (c == CH_EQ)) begin
				region_n         = match ? RG_CHECKED : RG_VALUE;
				token_starting_n = 1'b1;
				eq_hit           = 1'b1;
			end else if (no_quote && (c == CH_SLASH)) begin
				region_n = RG_OTHER;
			end else if (region_q == RG_KEY) begin
				// A new key token starts a fresh name.
				if (token_starting_q) begin
					attr_name_n      = '0;
					attr_len_n       = '0;
					overflow_n       = 1'b0;
					closed_n         = 1'b0;
					token_starting_n = 1'b0;
				end
				if (!closed_n) begin
					if (c_low == CH_NUL) begin
						closed_n = 1'b1;
					end else if (attr_len_n >= LEN_W'(MAX_NAME_CHARS)) begin
						overflow_n = 1'b1;
					end else begin
						for (int k = 0; k < MAX_NAME_CHARS; k++) begin
							if (attr_len_n == LEN_W'(k)) begin
								attr_name_n[8*k +: 8] = c_low;
							end
						end
						attr_len_n = attr_len_n + LEN_W'(1);
					end
				end
			end else if ((region_q == RG_VALUE) || (region_q == RG_CHECKED)) begin
				token_starting_n = 1'b0;
			end
			blank = eq_hit || (region_n != RG_CHECKED);
		end
	end

	// Scan state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_tag_q     <= 1'b0;
			open_quote_q     <= CH_NUL;
			token_starting_q <= 1'b0;
			region_q         <= RG_OTHER;
			attr_name_q      <= '0;
			attr_len_q       <= '0;
			overflow_q       <= 1'b0;
			closed_q         <= 1'b0;
		end else if (step) begin
			inside_tag_q     <= inside_tag_n;
			open_quote_q     <= open_quote_n;
			token_starting_q <= token_starting_n;
			region_q         <= region_n;
			attr_name_q      <= attr_name_n;
			attr_len_q       <= attr_len_n;
			overflow_q       <= overflow_n;
			closed_q         <= closed_n;
		end
	end

endmodule

@@ sim/tb_markup_blanking_scanner_unit.sv @@
// ---------------------------------------------------------------------------
// Testbench for the markup blanking scanner unit
// Feeds markup-like byte streams through the unit with random idle and stall
// bursts. A scoreboard tracks the scanner state, predicts every result beat
// and checks the beats in order. The checked attribute names are
// reprogrammed between phases, extreme settings included.
// ---------------------------------------------------------------------------
module tb_markup_blanking_scanner_unit;
	import mbs_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 10;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int MAX_REPORTS     = 10;
	localparam int CYCLE_LIMIT     = 400000;

	// Character classes used by the stimulus and the scoreboard.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_HIGH  = 8'hFF;
	localparam logic [7:0] UPPER_A  = 8'h41;
	localparam logic [7:0] UPPER_Z  = 8'h5A;
	localparam logic [7:0] LOWER_A  = 8'h61;
	localparam logic [7:0] LOWER_Z  = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	typedef struct packed {
		logic       blank;
		logic [7:0] ch;
	} beat_t;

	// Scanner state mirror and the queue of expected result beats.
	class markup_scoreboard;
		logic [CFG_DATA_W-1:0] name_reg [CHECK_NAMES_DEF];
		logic [USED_W-1:0]     names_used;
		bit                    inside_tag;
		logic [7:0]            open_quote;
		bit                    token_starting;
		region_t               region;
		logic [CFG_DATA_W-1:0] attr_name;
		int                    attr_len;
		bit                    attr_overflow;
		bit                    name_closed;
		beat_t                 expected_beats [$];
		int                    beats_seen;
		int                    mismatches;

		function new();
			name_reg[0] = CHECK_NAME_0_RST;
			for (int i = 1; i < CHECK_NAMES_DEF; i++)
				name_reg[i] = '0;
			names_used = CHECK_NAMES_USED_RST;
			inside_tag = 1'b0;
			open_quote = CH_NUL;
			token_starting = 1'b0;
			region = RG_OTHER;
			attr_name = '0;
			attr_len = 0;
			attr_overflow = 1'b0;
			name_closed = 1'b0;
			beats_seen = 0;
			mismatches = 0;
		endfunction

		// Register writes with an index past the last register are dropped.
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx < CFG_CHECK_NAMES_USED) begin
				name_reg[idx - CFG_CHECK_NAME_0] = val;
			end else if (idx == CFG_CHECK_NAMES_USED) begin
				names_used = val[USED_W-1:0];
			end
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// Advance the scanner by one accepted byte and queue its result beat.
		function void note_byte(logic [7:0] c);
			beat_t      nxt;
			logic [7:0] lc;
			int         n;
			bit         hit;
			bit         eq_mark;
			eq_mark = (open_quote == CH_NUL) && (c == CH_EQ);
			if (open_quote == CH_NUL && c == CH_LT) begin
				inside_tag = 1'b1;
				region = RG_KEY;
				token_starting = 1'b1;
				nxt.blank = 1'b1;
			end else if (open_quote == CH_NUL && c == CH_GT) begin
				// A closing bracket is markup even with no tag open.
				inside_tag = 1'b0;
				nxt.blank = 1'b1;
			end else if (!inside_tag) begin
				nxt.blank = 1'b0;
			end else begin
				if (c == CH_DQUOTE || c == CH_SQUOTE) begin
					if (open_quote == CH_NUL) begin
						open_quote = c;
					end else if (open_quote == c) begin
						open_quote = CH_NUL;
					end
				end else if (open_quote == CH_NUL &&
						(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
					if (!token_starting) begin
						region = RG_KEY;
						token_starting = 1'b1;
					end
				end else if (eq_mark) begin
					// Compare the collected name with the names in use.
					hit = 1'b0;
					n = names_used;
					if (n > CHECK_NAMES_DEF)
						n = CHECK_NAMES_DEF;
					for (int i = 0; i < n; i++) begin
						if (name_reg[i] == attr_name)
							hit = 1'b1;
					end
					region = (hit && !attr_overflow) ? RG_CHECKED : RG_VALUE;
					token_starting = 1'b1;
				end else if (open_quote == CH_NUL && c == CH_SLASH) begin
					region = RG_OTHER;
				end else if (region == RG_KEY) begin
					// A new key token clears the name; the name survives '<'.
					if (token_starting) begin
						attr_name = '0;
						attr_len = 0;
						attr_overflow = 1'b0;
						name_closed = 1'b0;
						token_starting = 1'b0;
					end
					lc = (c >= UPPER_A && c <= UPPER_Z) ? c + CASE_GAP : c;
					if (!name_closed) begin
						if (lc == CH_NUL) begin
							name_closed = 1'b1;
						end else if (attr_len >= MAX_NAME_CHARS_DEF) begin
							attr_overflow = 1'b1;
						end else begin
							attr_name |= CFG_DATA_W'(lc) << (8 * attr_len);
							attr_len++;
						end
					end
				end else if (region == RG_VALUE || region == RG_CHECKED) begin
					token_starting = 1'b0;
				end
				nxt.blank = eq_mark || (region != RG_CHECKED);
			end
			nxt.ch = nxt.blank ? CH_SPACE : c;
			expected_beats.push_back(nxt);
		endfunction

		// Compare one accepted result beat with the oldest expectation.
		function void check_beat(logic b, logic [7:0] ch);
			beat_t want;
			beats_seen++;
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: beat %0d arrived with nothing expected (blank=%0b out_char=%02h)",
						beats_seen, b, ch);
				return;
			end
			want = expected_beats.pop_front();
			if (b !== want.blank || ch !== want.ch) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: beat %0d expected blank=%0b out_char=%02h, got blank=%0b out_char=%02h",
						beats_seen, want.blank, want.ch, b, ch);
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index  = '0;
	logic [CFG_DATA_W-1:0] wr_data   = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [7:0]            in_char   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  blank;
	logic [7:0]            out_char;

	markup_scoreboard sb = new();
	logic [7:0]       doc_q [$];
	bit               idle_gaps    = 1'b1;
	bit               ready_stalls = 1'b1;
	bit               hold_off_req = 1'b0;
	int               bytes_sent   = 0;
	int               cycle_count  = 0;

	markup_blanking_scanner_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_char   (in_char),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.blank     (blank),
		.out_char  (out_char)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Handshakes are sampled mid-cycle, where every signal is settled.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_byte(in_char);
			if (out_valid && out_ready)
				sb.check_beat(blank, out_char);
		end
	end

	// Result side: ready and stall bursts, plus a long hold-off on request.
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (ready_stalls && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	function automatic logic [7:0] letter();
		logic [7:0] c;
		c = 8'($urandom_range(LOWER_A, LOWER_Z));
		if ($urandom_range(0, 3) == 0)
			c = c - CASE_GAP;
		return c;
	endfunction

	function automatic logic [7:0] space_byte();
		int r;
		r = $urandom_range(CH_TAB, CH_CR + 1);
		return (r > CH_CR) ? CH_SPACE : 8'(r);
	endfunction

	// Any byte, with a strong lean toward the characters the scanner reacts to.
	function automatic logic [7:0] text_byte();
		case ($urandom_range(0, 15))
			0: return 8'($urandom_range(0, 255));
			1: return CH_LT;
			2: return CH_GT;
			3: return CH_EQ;
			4: return CH_SLASH;
			5: return CH_DQUOTE;
			6: return CH_SQUOTE;
			7: return space_byte();
			8: return CH_NUL;
			default: return letter();
		endcase
	endfunction

	// Packs a lowercase name with its first character in the low byte.
	function automatic logic [CFG_DATA_W-1:0] pack_name(input string s);
		logic [CFG_DATA_W-1:0] v;
		v = '0;
		for (int i = 0; i < s.len() && i < MAX_NAME_CHARS_DEF; i++)
			v[8*i +: 8] = s[i];
		return v;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_name();
		logic [CFG_DATA_W-1:0] v;
		v = '0;
		for (int i = 0; i < $urandom_range(1, MAX_NAME_CHARS_DEF); i++)
			v[8*i +: 8] = 8'($urandom_range(LOWER_A, LOWER_Z));
		return v;
	endfunction

	// Appends a tag or attribute name: mostly a configured one, sometimes
	// cut by a zero byte, too long, empty or random.
	task automatic push_name();
		logic [CFG_DATA_W-1:0] src;
		logic [7:0]            c;
		int                    kind;
		int                    len;
		kind = $urandom_range(0, 9);
		src = sb.name_reg[$urandom_range(0, CHECK_NAMES_DEF - 1)];
		len = 0;
		while (len < MAX_NAME_CHARS_DEF && src[8*len +: 8] != CH_NUL)
			len++;
		if (kind <= 6) begin
			for (int i = 0; i < len; i++) begin
				c = src[8*i +: 8];
				if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(0, 1) == 1)
					c = c - CASE_GAP;
				doc_q.push_back(c);
			end
			if (kind == 5)
				doc_q.push_back(letter());
			if (kind == 6) begin
				doc_q.push_back(CH_NUL);
				repeat ($urandom_range(1, 3)) doc_q.push_back(letter());
			end
		end else if (kind == 7) begin
			repeat ($urandom_range(MAX_NAME_CHARS_DEF + 1, MAX_NAME_CHARS_DEF + 4))
				doc_q.push_back(letter());
		end else if (kind == 9) begin
			repeat ($urandom_range(1, MAX_NAME_CHARS_DEF))
				doc_q.push_back(($urandom_range(0, 1) == 1) ? letter() :
					8'($urandom_range(128, 255)));
		end
	endtask

	// Appends plain text, a tag with attributes, or a broken fragment.
	task automatic push_chunk();
		logic [7:0] q;
		int         kind;
		kind = $urandom_range(0, 19);
		if (kind < 6) begin
			repeat ($urandom_range(1, 8))
				doc_q.push_back(($urandom_range(0, 7) == 0) ? text_byte() :
					($urandom_range(0, 4) == 0) ? CH_SPACE : letter());
		end else if (kind < 17) begin
			doc_q.push_back(CH_LT);
			if ($urandom_range(0, 7) == 0) begin
				// '=' right after '<' compares the name left from before.
				doc_q.push_back(CH_EQ);
			end else begin
				if ($urandom_range(0, 5) == 0)
					doc_q.push_back(CH_SLASH);
				push_name();
			end
			repeat ($urandom_range(0, 3)) begin
				repeat ($urandom_range(1, 2)) doc_q.push_back(space_byte());
				push_name();
				if ($urandom_range(0, 4) != 0) begin
					if ($urandom_range(0, 3) == 0)
						doc_q.push_back(space_byte());
					doc_q.push_back(CH_EQ);
					if ($urandom_range(0, 3) == 0)
						doc_q.push_back(space_byte());
					case ($urandom_range(0, 3))
						0: ;
						1, 2: begin
							q = ($urandom_range(0, 1) == 1) ? CH_DQUOTE : CH_SQUOTE;
							doc_q.push_back(q);
							repeat ($urandom_range(0, 8)) doc_q.push_back(text_byte());
							if ($urandom_range(0, 15) != 0)
								doc_q.push_back(q);
						end
						default: repeat ($urandom_range(1, 6)) doc_q.push_back(letter());
					endcase
				end
			end
			if ($urandom_range(0, 3) == 0)
				doc_q.push_back(CH_SLASH);
			doc_q.push_back(CH_GT);
		end else begin
			repeat ($urandom_range(1, 10)) doc_q.push_back(text_byte());
		end
	endtask

	// Offers one byte and returns at the edge that accepts it.
	task automatic send_byte(input logic [7:0] c);
		in_valid <= 1'b1;
		in_char <= c;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		bytes_sent++;
		if (idle_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic send_doc();
		while (doc_q.size() > 0)
			send_byte(doc_q.pop_front());
	endtask

	task automatic send_random_text(input int n);
		int goal;
		goal = bytes_sent + n;
		while (bytes_sent < goal) begin
			push_chunk();
			send_doc();
		end
	endtask

	// Waits until every expected beat has come back and the unit is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	// Writes all registers; optionally pokes the unused indexes as well.
	task automatic configure(input logic [CFG_DATA_W-1:0] n0, input logic [CFG_DATA_W-1:0] n1,
			input logic [CFG_DATA_W-1:0] n2, input logic [CFG_DATA_W-1:0] n3,
			input logic [USED_W-1:0] used, input bit poke_unused);
		logic [CFG_DATA_W-1:0] names [CHECK_NAMES_DEF];
		logic [CFG_DATA_W-1:0] used_word;
		names[0] = n0;
		names[1] = n1;
		names[2] = n2;
		names[3] = n3;
		for (int i = 0; i < CHECK_NAMES_DEF; i++)
			write_reg(CFG_CHECK_NAME_0 + CFG_IDX_W'(i), names[i]);
		used_word = {$urandom, $urandom};
		used_word[USED_W-1:0] = used;
		write_reg(CFG_CHECK_NAMES_USED, used_word);
		if (poke_unused) begin
			for (int k = CFG_CHECK_NAMES_USED + 1; k < (1 << CFG_IDX_W); k++)
				write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
		end
		wr_en <= 1'b0;
	endtask

	initial begin
		string tag_text;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: a high byte and a stray '>' outside any tag, an
		// uppercase checked name with a quoted value holding '>', then a tag
		// that starts with '=' and reuses the name from the previous tag.
		tag_text = "x<IMG\tALT=\"a>b\"/><=q>";
		doc_q.push_back(CH_HIGH);
		doc_q.push_back(CH_GT);
		for (int i = 0; i < tag_text.len(); i++)
			doc_q.push_back(tag_text[i]);
		doc_q.push_back(CH_NUL);
		send_doc();
		send_random_text(150);

		// Long result hold-off while bytes keep coming.
		idle_gaps = 1'b0;
		hold_off_req = 1'b1;
		send_random_text(60);
		idle_gaps = 1'b1;

		// Sender pauses until everything has come back.
		drain();
		send_random_text(100);

		// All four names in use.
		drain();
		configure(pack_name("href"), pack_name("src"), pack_name("title"),
			pack_name("value"), 3'd4, 1'b0);
		send_random_text(250);

		// No names in use, with a full eight-character name and a zero name.
		drain();
		configure(pack_name("abcdefgh"), pack_name("src"), '0, pack_name("href"),
			3'd0, 1'b0);
		send_random_text(150);

		// Count above the name limit, all-ones and empty names, unused indexes.
		drain();
		configure('1, '0, pack_name("abcdefgh"), pack_name("id"), 3'd7, 1'b1);
		send_random_text(250);

		// Random names, and no idling on either side.
		drain();
		configure(rand_name(), rand_name(), rand_name(), rand_name(),
			USED_W'($urandom_range(1, CHECK_NAMES_DEF)), 1'b1);
		idle_gaps = 1'b0;
		ready_stalls = 1'b0;
		send_random_text(250);
		drain();

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/mbs_pkg.sv
sv/mbs_match.sv
sv/mbs_scan.sv
sv/markup_blanking_scanner_unit.sv
sim/tb_markup_blanking_scanner_unit.sv
